### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define REC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define REC_ASSERT_NORST(name, prop) \
  name: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define REC_ASSERT(name, prop)
`define REC_ASSERT_NORST(name, prop)
`endif
`endif

### hw/rtl/rec_pkg.sv
// shared types, constants and the cordic angle table
`default_nettype none
package rec_pkg;
  localparam int unsigned COORD_WIDTH_DEF   = 24;
  localparam int unsigned ANGLE_WIDTH_DEF   = 16;
  localparam int unsigned ROTATE_STAGES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH       = 4;

  localparam int unsigned SIZE_W = 20;  // radius and half sizes
  localparam int unsigned EXT_W  = 21;  // size enlarged by radius
  localparam int unsigned LIM_W  = 22;  // a+b+r
  localparam int unsigned DIFF_W = 23;  // offset once inside the bound
  localparam int unsigned ROT_W  = 34;  // rotated vector, 8 guard bits
  localparam int unsigned ANG_W  = 34;  // residual angle
  localparam int unsigned TURN_W = 32;  // angle, 2^32 per turn
  localparam int unsigned MAG_W  = 24;  // magnitude after gain fix
  localparam int unsigned GAIN_W = 31;

  localparam logic signed [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(652032874);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd1073741824);

  typedef struct packed {
    logic                    kill;
    logic                    is_rect;
    logic [EXT_W-1:0]        ext_a;
    logic [EXT_W-1:0]        ext_b;
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } rec_item_t;

  function automatic logic signed [ANG_W-1:0] atan_f(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return $signed({{(ANG_W-32){1'b0}}, v});
  endfunction
endpackage
`default_nettype wire

### hw/rtl/rotated_ellipse_collision_test_top.sv
// Point-versus-ellipse/rectangle collision test. One object pair enters per clock
// while results are taken, and its hit flag leaves after the ROTATE_STAGES cordic
// stages, a two-stage gain fix and a five-stage exact square compare; sustained
// rate is one pair per cycle. A four-item queue sits between the offset/bound front
// end and the pipelined back end, and the back end stalls as a
// whole while its result is not taken. No configuration, no clearing after reset.
`default_nettype none
module rotated_ellipse_collision_test_top #(
  parameter int unsigned COORD_WIDTH   = rec_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH   = rec_pkg::ANGLE_WIDTH_DEF,
  parameter int unsigned ROTATE_STAGES = rec_pkg::ROTATE_STAGES_DEF,
  localparam int unsigned IN_BITS      = 4 * COORD_WIDTH + ANGLE_WIDTH + 62,
  localparam int unsigned IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // first_enabled, first_x, first_y, first_radius, first_rotation, second_enabled,
  // second_x, second_y, second_half_a, second_half_b, zero fill
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  // second_is_rect
  input  wire logic                  s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // hit, zero fill
  output logic [7:0]                 m_axis_tdata_o
);
  import rec_pkg::*;

  localparam int unsigned O_FX  = 1;
  localparam int unsigned O_FY  = O_FX + COORD_WIDTH;
  localparam int unsigned O_FR  = O_FY + COORD_WIDTH;
  localparam int unsigned O_ROT = O_FR + SIZE_W;
  localparam int unsigned O_SE  = O_ROT + ANGLE_WIDTH;
  localparam int unsigned O_SX  = O_SE + 1;
  localparam int unsigned O_SY  = O_SX + COORD_WIDTH;
  localparam int unsigned O_A   = O_SY + COORD_WIDTH;
  localparam int unsigned O_B   = O_A + SIZE_W;

  logic      push, full, pop, empty, hit;
  rec_item_t front_item, back_item;

  rec_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s_axis_tvalid_i),
    .ready_o         (s_axis_tready_o),
    .first_enabled_i (s_axis_tdata_i[0]),
    .first_x_i       (s_axis_tdata_i[O_FX +: COORD_WIDTH]),
    .first_y_i       (s_axis_tdata_i[O_FY +: COORD_WIDTH]),
    .first_radius_i  (s_axis_tdata_i[O_FR +: SIZE_W]),
    .first_rotation_i(s_axis_tdata_i[O_ROT +: ANGLE_WIDTH]),
    .second_enabled_i(s_axis_tdata_i[O_SE]),
    .second_x_i      (s_axis_tdata_i[O_SX +: COORD_WIDTH]),
    .second_y_i      (s_axis_tdata_i[O_SY +: COORD_WIDTH]),
    .second_half_a_i (s_axis_tdata_i[O_A +: SIZE_W]),
    .second_half_b_i (s_axis_tdata_i[O_B +: SIZE_W]),
    .second_is_rect_i(s_axis_tuser_i),
    .push_o          (push),
    .item_o          (front_item),
    .full_i          (full)
  );

  rec_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_item),
    .full_o (full),
    .pop_i  (pop),
    .data_o (back_item),
    .empty_o(empty)
  );

  rec_back #(
    .ROTATE_STAGES(ROTATE_STAGES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pop_o  (pop),
    .item_i (back_item),
    .empty_i(empty),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .hit_o  (hit)
  );

  assign m_axis_tdata_o = {7'b0, hit};
endmodule
`default_nettype wire

### hw/rtl/rec_front.sv
// front end: takes pairs, forms offsets, bound check and quarter-turn pre-rotation
`default_nettype none
module rec_front #(
  parameter int unsigned COORD_WIDTH = rec_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = rec_pkg::ANGLE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic                          first_enabled_i,
  input  wire logic [COORD_WIDTH-1:0]        first_x_i,
  input  wire logic [COORD_WIDTH-1:0]        first_y_i,
  input  wire logic [rec_pkg::SIZE_W-1:0]    first_radius_i,
  input  wire logic [ANGLE_WIDTH-1:0]        first_rotation_i,
  input  wire logic                          second_enabled_i,
  input  wire logic [COORD_WIDTH-1:0]        second_x_i,
  input  wire logic [COORD_WIDTH-1:0]        second_y_i,
  input  wire logic [rec_pkg::SIZE_W-1:0]    second_half_a_i,
  input  wire logic [rec_pkg::SIZE_W-1:0]    second_half_b_i,
  input  wire logic                          second_is_rect_i,
  output logic                               push_o,
  output rec_pkg::rec_item_t                 item_o,
  input  wire logic                          full_i
);
  import rec_pkg::*;

  localparam int unsigned DW    = COORD_WIDTH + 1;
  localparam int unsigned CMP_W = (DW > LIM_W) ? DW : LIM_W;

  logic                     vld_q, vld_d;
  logic                     off_q, rect_q;
  logic signed [DW-1:0]     dx_q, dy_q;
  logic [LIM_W-1:0]         lim_q;
  logic [EXT_W-1:0]         ea_q, eb_q;
  logic signed [TURN_W-1:0] z_q;
  logic [ANGLE_WIDTH-1:0]   neg_rot;
  logic                     accept;
  logic [DW-1:0]            mx, my;
  logic                     outside;
  logic signed [DIFF_W-1:0] dxs, dys;
  logic signed [ROT_W-1:0]  x0, y0;
  logic signed [ANG_W-1:0]  z0;

  assign ready_o = !vld_q || !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = vld_q && !full_i;
  assign neg_rot = ~first_rotation_i + 1'b1;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      off_q  <= !(first_enabled_i && second_enabled_i);
      rect_q <= second_is_rect_i;
      dx_q   <= $signed({second_x_i[COORD_WIDTH-1], second_x_i})
              - $signed({first_x_i[COORD_WIDTH-1], first_x_i});
      dy_q   <= $signed({second_y_i[COORD_WIDTH-1], second_y_i})
              - $signed({first_y_i[COORD_WIDTH-1], first_y_i});
      lim_q  <= LIM_W'(second_half_a_i) + LIM_W'(second_half_b_i)
              + LIM_W'(first_radius_i);
      ea_q   <= EXT_W'(second_half_a_i) + EXT_W'(first_radius_i);
      eb_q   <= EXT_W'(second_half_b_i) + EXT_W'(first_radius_i);
      z_q    <= $signed({neg_rot, {(TURN_W-ANGLE_WIDTH){1'b0}}});
    end
  end

  assign mx = dx_q[DW-1] ? (~$unsigned(dx_q) + 1'b1) : $unsigned(dx_q);
  assign my = dy_q[DW-1] ? (~$unsigned(dy_q) + 1'b1) : $unsigned(dy_q);
  assign outside = (CMP_W'(mx) > CMP_W'(lim_q)) || (CMP_W'(my) > CMP_W'(lim_q));

  // offsets are narrow once inside the bound
  assign dxs = DIFF_W'(dx_q);
  assign dys = DIFF_W'(dy_q);

  always_comb begin
    x0 = ROT_W'($signed({dxs, 8'h00}));
    y0 = ROT_W'($signed({dys, 8'h00}));
    z0 = ANG_W'(z_q);
    if (z0 > QUARTER_TURN) begin
      x0 = -ROT_W'($signed({dys, 8'h00}));
      y0 = ROT_W'($signed({dxs, 8'h00}));
      z0 = ANG_W'(z_q) - QUARTER_TURN;
    end else if (z0 < -QUARTER_TURN) begin
      x0 = ROT_W'($signed({dys, 8'h00}));
      y0 = -ROT_W'($signed({dxs, 8'h00}));
      z0 = ANG_W'(z_q) + QUARTER_TURN;
    end
  end

  always_comb begin
    item_o.kill    = off_q || outside;
    item_o.is_rect = rect_q;
    item_o.ext_a   = ea_q;
    item_o.ext_b   = eb_q;
    item_o.x       = x0;
    item_o.y       = y0;
    item_o.z       = z0;
  end
endmodule
`default_nettype wire

### hw/rtl/rec_fifo.sv
// short item queue between front and back
`default_nettype none
`include "assert_macros.svh"
module rec_fifo #(
  parameter int unsigned DEPTH = rec_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rec_pkg::rec_item_t data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output rec_pkg::rec_item_t      data_o,
  output logic                    empty_o
);
  import rec_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rec_item_t       mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `REC_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH))
  `REC_ASSERT(a_no_push_full, push_i |-> !full_o)
  `REC_ASSERT(a_no_pop_empty, pop_i |-> !empty_o)
  `REC_ASSERT(a_cnt_up, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
endmodule
`default_nettype wire

### hw/rtl/rec_back.sv
// back end: cordic rotation, gain fix and exact shape test in one pipeline
`default_nettype none
`include "assert_macros.svh"
module rec_back #(
  parameter int unsigned ROTATE_STAGES = rec_pkg::ROTATE_STAGES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  output logic                    pop_o,
  input  wire rec_pkg::rec_item_t item_i,
  input  wire logic               empty_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic                    hit_o
);
  import rec_pkg::*;

  localparam int unsigned RS  = ROTATE_STAGES;
  localparam int unsigned NV  = RS + 8;
  localparam int unsigned PRW = 49;  // gain partial product
  localparam int unsigned SW  = 66;  // gain sum
  localparam int unsigned PW  = 45;  // x*B, y*A, A*B
  localparam int unsigned LW  = 23;  // low half when squaring
  localparam int unsigned HW  = PW - LW;
  localparam int unsigned QW  = 2 * PW;

  typedef struct packed {
    logic             kill;
    logic             is_rect;
    logic [EXT_W-1:0] ext_a;
    logic [EXT_W-1:0] ext_b;
  } side_t;

  logic                    en;
  logic [NV-1:0]           vld_q, vld_d;
  side_t                   side_q [NV];
  logic signed [ROT_W-1:0] cx_q [RS+1];
  logic signed [ROT_W-1:0] cy_q [RS+1];
  logic signed [ANG_W-1:0] cz_q [RS+1];

  logic signed [PRW-1:0]   gxh_q, gxl_q, gyh_q, gyl_q;
  logic signed [SW-1:0]    sx, sy;
  logic signed [SW-39:0]   rx, ry;
  logic [SW-38:0]          ax, ay;
  logic [MAG_W-1:0]        xm_q, ym_q;
  logic [2*MAG_W-1:0]      xx_q, yy_q;
  logic [2*EXT_W-1:0]      aa_q, bb_q;
  logic [PW-1:0]           xb_q, ya_q, ab_q;
  logic                    rh2_q, rh3_q, rh4_q;
  logic [2*HW-1:0]         hh_q [3];
  logic [PW-1:0]           hl_q [3];
  logic [2*LW-1:0]         ll_q [3];
  logic [PW-1:0]           sq_src [3];
  logic [QW-1:0]           sq_q [3];
  logic [QW:0]             lhs_q;
  logic [QW-1:0]           rhs_q;
  logic                    hit_q;

  assign en      = !vld_q[NV-1] || ready_i;
  assign pop_o   = en && !empty_i;
  assign valid_o = vld_q[NV-1];
  assign hit_o   = hit_q;

  assign vld_d = en ? {vld_q[NV-2:0], pop_o} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0]   <= item_i.x;
      cy_q[0]   <= item_i.y;
      cz_q[0]   <= item_i.z;
      side_q[0] <= '{kill: item_i.kill, is_rect: item_i.is_rect,
                     ext_a: item_i.ext_a, ext_b: item_i.ext_b};
    end
  end

  for (genvar k = 0; k < NV - 1; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  for (genvar i = 0; i < RS; i++) begin : g_cordic
    logic signed [ROT_W-1:0] shx, shy;
    logic                    dir;
    assign shx = cx_q[i] >>> i;
    assign shy = cy_q[i] >>> i;
    assign dir = !cz_q[i][ANG_W-1];
    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[i+1] <= dir ? cx_q[i] - shy : cx_q[i] + shy;
        cy_q[i+1] <= dir ? cy_q[i] + shx : cy_q[i] - shx;
        cz_q[i+1] <= dir ? cz_q[i] - atan_f(i) : cz_q[i] + atan_f(i);
      end
    end
  end

  // gain: split the vector into a signed high and unsigned low part
  always_ff @(posedge clk_i) begin
    if (en) begin
      gxh_q <= PRW'($signed(cx_q[RS][ROT_W-1:17]) * GAIN_Q30);
      gxl_q <= PRW'($signed({1'b0, cx_q[RS][16:0]}) * GAIN_Q30);
      gyh_q <= PRW'($signed(cy_q[RS][ROT_W-1:17]) * GAIN_Q30);
      gyl_q <= PRW'($signed({1'b0, cy_q[RS][16:0]}) * GAIN_Q30);
    end
  end

  assign sx = (SW'(gxh_q) <<< 17) + SW'(gxl_q) + (SW'(1) <<< 37);
  assign sy = (SW'(gyh_q) <<< 17) + SW'(gyl_q) + (SW'(1) <<< 37);
  assign rx = sx[SW-1:38];
  assign ry = sy[SW-1:38];
  assign ax = rx[SW-39] ? (~{rx[SW-39], $unsigned(rx)} + 1'b1) : {1'b0, $unsigned(rx)};
  assign ay = ry[SW-39] ? (~{ry[SW-39], $unsigned(ry)} + 1'b1) : {1'b0, $unsigned(ry)};

  always_ff @(posedge clk_i) begin
    if (en) begin
      xm_q <= ax[MAG_W-1:0];
      ym_q <= ay[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q <= xm_q * xm_q;
      yy_q <= ym_q * ym_q;
      aa_q <= side_q[RS+2].ext_a * side_q[RS+2].ext_a;
      bb_q <= side_q[RS+2].ext_b * side_q[RS+2].ext_b;
      xb_q <= xm_q * side_q[RS+2].ext_b;
      ya_q <= ym_q * side_q[RS+2].ext_a;
      ab_q <= PW'(side_q[RS+2].ext_a * side_q[RS+2].ext_b);
    end
  end

  assign sq_src[0] = xb_q;
  assign sq_src[1] = ya_q;
  assign sq_src[2] = ab_q;

  // squares of 45-bit products from three narrower partial products
  for (genvar j = 0; j < 3; j++) begin : g_square
    always_ff @(posedge clk_i) begin
      if (en) begin
        hh_q[j] <= sq_src[j][PW-1:LW] * sq_src[j][PW-1:LW];
        hl_q[j] <= sq_src[j][PW-1:LW] * sq_src[j][LW-1:0];
        ll_q[j] <= sq_src[j][LW-1:0] * sq_src[j][LW-1:0];
        sq_q[j] <= ({hh_q[j], {(2*LW){1'b0}}})
                 + (QW'(hl_q[j]) << (LW + 1))
                 + QW'(ll_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rh2_q <= (xx_q < (2*MAG_W)'(aa_q)) && (yy_q < (2*MAG_W)'(bb_q));
      rh3_q <= rh2_q;
      rh4_q <= rh3_q;
      lhs_q <= (QW+1)'(sq_q[0]) + (QW+1)'(sq_q[1]);
      rhs_q <= sq_q[2];
      hit_q <= !side_q[NV-2].kill
             && (side_q[NV-2].is_rect ? rh4_q : (lhs_q < (QW+1)'(rhs_q)));
    end
  end

  `REC_ASSERT(a_kill_no_hit, (valid_o && side_q[NV-1].kill) |-> !hit_o)
  `REC_ASSERT(a_flat_ellipse, (valid_o && !side_q[NV-1].is_rect
    && (side_q[NV-1].ext_a == '0 || side_q[NV-1].ext_b == '0)) |-> !hit_o)
  `REC_ASSERT(a_pop_enters, pop_o |=> vld_q[0])
endmodule
`default_nettype wire
